FILE: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants and codes for the text console writer and its cell store.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int CELL_W          = 16;
   localparam int TAB_STOP        = 4;
   localparam int POS_W           = 11;
   localparam int INDEX_W         = 11;
   localparam int LINES_W         = 5;

   localparam logic [7:0] ATTR_RESET = 8'h07;

   localparam logic [7:0] CHAR_BS  = 8'd8;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_NL  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;

   typedef enum logic [1:0] {
      KIND_PUT    = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_SCROLL = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

endpackage

FILE: sv/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// Text console cell store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module tcw_cell_ram
   import tcw_pkg::*;
#(
   parameter int DEPTH  = COLUMNS_DEFAULT * ROWS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// A clear, and a scroll or a put that runs past the last row, walk the cell store
// one cell per cycle. A backspace at column zero, a read beyond the store or a
// scroll by zero lines goes straight to the response. A stall on the response
// holds the writer, and one transfer is in work at a time. Reset is synchronous.
// After reset a clearing pass zeroes the cell store, and no request is taken
// while it runs.
// ----------------------------------------------------------------------------
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], scroll_lines[12:8], cell_index[23:13]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_pos[10:0], cell_char[18:11], cell_attr[26:19]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int AI     = $clog2(CELLS);
   localparam int AW     = $clog2(CELLS + 1);
   localparam int CW     = $clog2(COLUMNS);
   localparam int RW     = $clog2(ROWS + 1);
   localparam int SHW    = $clog2(((1 << LINES_W) - 1) * COLUMNS + 1);
   localparam int SRCW   = $clog2(CELLS + ((1 << LINES_W) - 1) * COLUMNS + 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_BACKSPACE,
      ST_SCROLL,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic               reply_ff;
   logic [AW-1:0]      idx_ff;
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;
   logic [7:0]         attr_ff;
   logic [LINES_W-1:0] lines_ff;
   logic [SHW-1:0]     shift_ff;
   logic               copy_ff;
   logic               pend_ff;
   logic [AI-1:0]      pend_addr_ff;
   logic               pend_copy_ff;
   logic [7:0]         rd_char_ff;
   logic [7:0]         rd_attr_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   logic               accept;
   kind_type           kind;
   logic [7:0]         code;
   logic [LINES_W-1:0] lines;
   logic [INDEX_W-1:0] index;
   logic               read_hit;
   logic [AI-1:0]      cur_pos;
   logic [CW:0]        col_inc;
   logic [CW:0]        col_tab;
   logic [CW:0]        put_col_in;
   logic [RW-1:0]      put_row_in;
   logic               put_ctrl;
   logic [SRCW-1:0]    src;
   logic               src_copy;
   logic               mem_wr_en;
   logic [AI-1:0]      mem_wr_addr;
   logic [CELL_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [AI-1:0]      mem_rd_addr;
   logic [CELL_W-1:0]  mem_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign code       = req_tdata[7:0];
   assign lines      = req_tdata[12:8];
   assign index      = req_tdata[23:13];
   assign read_hit   = (AW + INDEX_W)'(index) < (AW + INDEX_W)'(CELLS);
   assign cur_pos    = AI'(AI'(row_ff) * AI'(COLUMNS) + AI'(col_ff));
   assign col_inc    = {1'b0, col_ff} + (CW + 1)'(1);
   assign col_tab    = ({1'b0, col_ff} | (CW + 1)'(TAB_STOP - 1)) + (CW + 1)'(1);
   assign put_ctrl   = (code == CHAR_BS) || (code == CHAR_TAB) || (code == CHAR_NL)
                       || (code == CHAR_CR);
   assign src        = SRCW'(idx_ff) + SRCW'(shift_ff);
   assign src_copy   = copy_ff && (src < SRCW'(CELLS));

   always_comb begin
      put_col_in = {1'b0, col_ff};
      put_row_in = row_ff;
      unique case (code)
         CHAR_NL: begin
            put_col_in = '0;
            put_row_in = row_ff + RW'(1);
         end
         CHAR_CR: begin
            put_col_in = '0;
         end
         CHAR_BS: begin
            put_col_in = {1'b0, col_ff};
         end
         CHAR_TAB: begin
            put_col_in = col_tab;
         end
         default: begin
            put_col_in = col_inc;
         end
      endcase
      if ((code != CHAR_BS) && (put_col_in > (CW + 1)'(COLUMNS - 1))) begin
         put_col_in = '0;
         put_row_in = row_ff + RW'(1);
      end
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AI-1:0];
         end
         ST_IDLE: begin
            if (accept && (kind == KIND_PUT)) begin
               if (code == CHAR_BS) begin
                  mem_rd_en   = (col_ff != '0);
                  mem_rd_addr = cur_pos;
               end else if (!put_ctrl) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = cur_pos;
                  mem_wr_data = {attr_ff, code};
               end
            end else if (accept && (kind == KIND_READ)) begin
               mem_rd_en   = read_hit;
               mem_rd_addr = AI'(index);
            end
         end
         ST_BACKSPACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_pos;
            mem_wr_data = {8'h00, mem_rd_data[7:0]};
         end
         ST_SCROLL: begin
            if ((idx_ff < AW'(CELLS)) && src_copy) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AI'(src);
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff;
               mem_wr_data = pend_copy_ff ? mem_rd_data : {attr_ff, 8'h00};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         reply_ff     <= 1'b0;
         idx_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_SWEEP: begin
               if (idx_ff == AW'(CELLS - 1)) begin
                  idx_ff   <= '0;
                  col_ff   <= '0;
                  row_ff   <= '0;
                  state_ff <= reply_ff ? ST_DONE : ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  rd_char_ff <= '0;
                  rd_attr_ff <= '0;
                  unique case (kind)
                     KIND_PUT: begin
                        if (code == CHAR_BS) begin
                           state_ff <= (col_ff != '0) ? ST_BACKSPACE : ST_DONE;
                        end else begin
                           col_ff <= put_col_in[CW-1:0];
                           row_ff <= put_row_in;
                           if (put_row_in > RW'(ROWS - 1)) begin
                              lines_ff <= LINES_W'(1);
                              shift_ff <= SHW'(COLUMNS);
                              copy_ff  <= 1'b1;
                              idx_ff   <= '0;
                              pend_ff  <= 1'b0;
                              state_ff <= ST_SCROLL;
                           end else begin
                              state_ff <= ST_DONE;
                           end
                        end
                     end
                     KIND_CLEAR: begin
                        reply_ff <= 1'b1;
                        idx_ff   <= '0;
                        state_ff <= ST_SWEEP;
                     end
                     KIND_SCROLL: begin
                        if (lines == '0) begin
                           state_ff <= ST_DONE;
                        end else begin
                           lines_ff <= lines;
                           shift_ff <= SHW'(SHW'(lines) * SHW'(COLUMNS));
                           copy_ff  <= (32'(lines) < 32'(ROWS));
                           idx_ff   <= '0;
                           pend_ff  <= 1'b0;
                           state_ff <= ST_SCROLL;
                        end
                     end
                     KIND_READ: begin
                        state_ff <= read_hit ? ST_READ : ST_DONE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rd_char_ff <= mem_rd_data[7:0];
               rd_attr_ff <= mem_rd_data[15:8];
               state_ff   <= ST_DONE;
            end
            ST_BACKSPACE: begin
               col_ff   <= col_ff - CW'(1);
               state_ff <= ST_DONE;
            end
            ST_SCROLL: begin
               if (idx_ff < AW'(CELLS)) begin
                  pend_ff      <= 1'b1;
                  pend_addr_ff <= idx_ff[AI-1:0];
                  pend_copy_ff <= src_copy;
                  idx_ff       <= idx_ff + AW'(1);
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     idx_ff <= '0;
                     if (32'(row_ff) > 32'(lines_ff)) begin
                        row_ff <= RW'(32'(row_ff) - 32'(lines_ff));
                     end else begin
                        row_ff <= '0;
                     end
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'd0, rd_attr_ff, rd_char_ff, POS_W'(cur_pos)};
                  reply_ff     <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (AI)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
